FILE: rtl/newr_pkg.sv
// Shared constants, codes and types for the nearest-point-within-radius search.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package newr_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int MAX_POINTS_DEF = 1024;
    localparam int MAX_DIM_DEF    = 128;

    // Field widths fixed by the interface
    localparam int OP_W      = 2;
    localparam int COORD_W   = 16;
    localparam int DIST_W    = 40;
    localparam int ROOT_W    = 28;
    localparam int FRAC_BITS = 8;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIM_CFG_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = DIST_W;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input opcodes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd1;

    // Reset values of the configuration registers
    localparam int SEARCH_RADIUS = 300;
    localparam logic [DIM_CFG_W-1:0] DIM_RESET       = 8'd128;
    localparam logic [DIST_W-1:0]    RADIUS_SQ_RESET = DIST_W'(SEARCH_RADIUS * SEARCH_RADIUS);

    // Saturation value of a squared sum
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic {
        CMD_POINT,
        CMD_QUERY
    } cmd_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_ROOT,
        B_OUT
    } back_state_t;

endpackage

FILE: rtl/newr_front.sv
// Front end: accepts input beats, tracks load/query indexes and point count,
// and turns load and query beats into store-write and query commands. Uses newr_pkg.

module newr_front #(
    parameter int MAX_POINTS = newr_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIM    = newr_pkg::MAX_DIM_DEF,
    localparam int CW  = $clog2(MAX_POINTS + 1),
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DW  = $clog2(MAX_DIM + 1),
    localparam int SAW = (MAX_POINTS * MAX_DIM > 1) ? $clog2(MAX_POINTS * MAX_DIM) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [newr_pkg::OP_W-1:0]         op,
    input  logic signed [newr_pkg::COORD_W-1:0] coord_value,
    input  logic [DW-1:0]                     dim,
    input  logic                              q_full,
    output logic                              push,
    output newr_pkg::cmd_kind_t               cmd_kind,
    output logic                              cmd_last,
    output logic [newr_pkg::COORD_W-1:0]      cmd_coord,
    output logic [SAW-1:0]                    cmd_addr,
    output logic [CW-1:0]                     cmd_count
);

    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  lidx_reg, lidx_next;
    logic [SAW-1:0] lbase_reg, lbase_next;
    logic [IW-1:0]  qidx_reg, qidx_next;
    logic [DW-1:0]  lnxt, qnxt;
    logic           accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign lnxt     = DW'(lidx_reg) + DW'(1);
    assign qnxt     = DW'(qidx_reg) + DW'(1);

    always_comb
    begin
        count_next = count_reg;
        lidx_next  = lidx_reg;
        lbase_next = lbase_reg;
        qidx_next  = qidx_reg;
        push       = 1'b0;
        cmd_kind   = newr_pkg::CMD_POINT;
        cmd_last   = 1'b0;
        cmd_coord  = coord_value;
        cmd_addr   = lbase_reg + SAW'(lidx_reg);
        cmd_count  = count_reg;
        if (accept)
        begin
            unique case (op)
                newr_pkg::OP_LOAD:
                begin
                    // store full: the coordinate is dropped
                    if (count_reg != CW'(MAX_POINTS))
                    begin
                        push = 1'b1;
                        if (lnxt >= dim)
                        begin
                            lidx_next  = '0;
                            count_next = count_reg + CW'(1);
                            lbase_next = lbase_reg + SAW'(MAX_DIM);
                        end
                        else
                        begin
                            lidx_next = IW'(lnxt);
                        end
                    end
                end
                newr_pkg::OP_QUERY:
                begin
                    push     = 1'b1;
                    cmd_kind = newr_pkg::CMD_QUERY;
                    cmd_addr = SAW'(qidx_reg);
                    if (qnxt >= dim)
                    begin
                        cmd_last  = 1'b1;
                        qidx_next = '0;
                    end
                    else
                    begin
                        qidx_next = IW'(qnxt);
                    end
                end
                newr_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                    lidx_next  = '0;
                    lbase_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lidx_reg  <= '0;
            lbase_reg <= '0;
            qidx_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            lidx_reg  <= lidx_next;
            lbase_reg <= lbase_next;
            qidx_reg  <= qidx_next;
        end
    end

endmodule

FILE: rtl/newr_queue.sv
// Small register FIFO that decouples the front end from the back end.
// Uses newr_pkg for the default depth.

module newr_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = newr_pkg::QUEUE_DEPTH,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + NW'(1);
                2'b01:   count_reg <= count_reg - NW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/newr_sqrt.sv
// Bit-serial integer square root: floor(sqrt(value * 2^16)), one root bit a cycle.
// Uses newr_pkg for widths.

module newr_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [newr_pkg::DIST_W-1:0]   value,
    output logic                          done,
    output logic [newr_pkg::ROOT_W-1:0]   root
);

    localparam int RW     = newr_pkg::ROOT_W;
    localparam int RAD_W  = 2 * RW;
    localparam int STEP_W = $clog2(RW);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  x_reg;
    logic [RW+1:0]     rem_reg;
    logic [RW-1:0]     root_reg;
    logic [RW+1:0]     rem_shift, trial;
    logic              fits;

    // remainder never exceeds 2*root, so its top two bits are zero before the shift
    assign rem_shift = {rem_reg[RW-1:0], x_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);
    assign done      = busy_reg && (step_reg == STEP_W'(RW - 1));
    assign root      = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= RAD_W'(value) << (RAD_W - newr_pkg::DIST_W);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= x_reg << 2;
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: rtl/newr_back.sv
// Back end: owns the point store and query buffer, executes queued commands,
// scans all points through a distance pipeline and roots the best sum.
// Uses newr_pkg and newr_sqrt.

module newr_back #(
    parameter int MAX_POINTS = newr_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIM    = newr_pkg::MAX_DIM_DEF,
    localparam int CW  = $clog2(MAX_POINTS + 1),
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int DW  = $clog2(MAX_DIM + 1),
    localparam int SAW = (MAX_POINTS * MAX_DIM > 1) ? $clog2(MAX_POINTS * MAX_DIM) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [DW-1:0]                   dim,
    input  logic [newr_pkg::DIST_W-1:0]     radius_sq,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  newr_pkg::cmd_kind_t             h_kind,
    input  logic                            h_last,
    input  logic [newr_pkg::COORD_W-1:0]    h_coord,
    input  logic [SAW-1:0]                  h_addr,
    input  logic [CW-1:0]                   h_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [newr_pkg::DIST_W-1:0]     min_dist_squared,
    output logic [newr_pkg::ROOT_W-1:0]     min_distance_fx
);

    localparam int CRD = newr_pkg::COORD_W;
    localparam int DSW = newr_pkg::DIST_W;
    localparam int SQW = newr_pkg::SQ_W;
    localparam int STORE_DEPTH = MAX_POINTS * MAX_DIM;

    newr_pkg::back_state_t state_reg, state_next;

    // memories
    logic [CRD-1:0] store_mem [STORE_DEPTH];
    logic [CRD-1:0] qbuf_mem  [MAX_DIM];

    // scan counters
    logic [CW-1:0]  npts_reg;
    logic [CW-1:0]  pt_reg;
    logic [IW-1:0]  q_reg;
    logic [SAW-1:0] base_reg;
    logic           last_coord, last_point;

    // distance pipeline
    logic           v1_reg, f1_reg, l1_reg;
    logic           v2_reg, f2_reg, l2_reg;
    logic           v3_reg, f3_reg, l3_reg;
    logic           v4_reg;
    logic [CRD-1:0] rd_p_reg, rd_q_reg;
    logic [CRD-1:0] adiff_reg;
    logic [SQW-1:0] sq_reg;
    logic [DSW-1:0] acc_reg;
    logic signed [CRD:0] diff;
    logic [CRD:0]   mag;
    logic [DSW:0]   acc_sum;
    logic [DSW-1:0] acc_next;
    logic           pipe_empty;

    // best match
    logic           found_reg;
    logic [DSW-1:0] best_reg;

    // control strobes
    logic issue, scan_start, sqrt_start, sqrt_done, out_load;
    logic [newr_pkg::ROOT_W-1:0] root;
    logic out_valid_reg;

    assign last_coord = (DW'(q_reg) + DW'(1) == dim);
    assign last_point = (pt_reg + CW'(1) == npts_reg);
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            newr_pkg::B_IDLE:
            begin
                if (!q_empty && h_kind == newr_pkg::CMD_QUERY && h_last)
                begin
                    state_next = (h_count == '0) ? newr_pkg::B_DRAIN : newr_pkg::B_SCAN;
                end
            end
            newr_pkg::B_SCAN:
            begin
                if (last_coord && last_point)
                begin
                    state_next = newr_pkg::B_DRAIN;
                end
            end
            newr_pkg::B_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = newr_pkg::B_ROOT;
                end
            end
            newr_pkg::B_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = newr_pkg::B_OUT;
                end
            end
            newr_pkg::B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = newr_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = newr_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = (state_reg == newr_pkg::B_IDLE) && !q_empty;
        scan_start = q_pop && (h_kind == newr_pkg::CMD_QUERY) && h_last;
        issue      = (state_reg == newr_pkg::B_SCAN);
        sqrt_start = (state_reg == newr_pkg::B_DRAIN) && pipe_empty;
        out_load   = (state_reg == newr_pkg::B_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= newr_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (q_pop && h_kind == newr_pkg::CMD_POINT)
        begin
            store_mem[h_addr] <= h_coord;
        end
        rd_p_reg <= store_mem[base_reg + SAW'(q_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && h_kind == newr_pkg::CMD_QUERY)
        begin
            qbuf_mem[h_addr[IW-1:0]] <= h_coord;
        end
        rd_q_reg <= qbuf_mem[q_reg];
    end

    // ---------------- scan counters ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npts_reg <= '0;
            pt_reg   <= '0;
            q_reg    <= '0;
            base_reg <= '0;
        end
        else if (scan_start)
        begin
            npts_reg <= h_count;
            pt_reg   <= '0;
            q_reg    <= '0;
            base_reg <= '0;
        end
        else if (issue)
        begin
            if (last_coord)
            begin
                q_reg    <= '0;
                pt_reg   <= pt_reg + CW'(1);
                base_reg <= base_reg + SAW'(MAX_DIM);
            end
            else
            begin
                q_reg <= q_reg + IW'(1);
            end
        end
    end

    // ---------------- distance pipeline ----------------
    assign diff = $signed({rd_p_reg[CRD-1], rd_p_reg}) - $signed({rd_q_reg[CRD-1], rd_q_reg});
    assign mag  = diff[CRD] ? (~diff + (CRD + 1)'(1)) : diff;

    assign acc_sum  = (f3_reg ? '0 : {1'b0, acc_reg}) + (DSW + 1)'(sq_reg);
    assign acc_next = acc_sum[DSW] ? newr_pkg::DIST_MAX : acc_sum[DSW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            f1_reg <= 1'b0;
            l1_reg <= 1'b0;
            f2_reg <= 1'b0;
            l2_reg <= 1'b0;
            f3_reg <= 1'b0;
            l3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            f1_reg <= (q_reg == '0);
            l1_reg <= last_coord;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
            l2_reg <= l1_reg;
            v3_reg <= v2_reg;
            f3_reg <= f2_reg;
            l3_reg <= l2_reg;
            v4_reg <= v3_reg && l3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        adiff_reg <= mag[CRD-1:0];
        sq_reg    <= adiff_reg * adiff_reg;
        if (v3_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // compare a finished sum against the radius and the best so far
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if (scan_start)
        begin
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if (v4_reg && acc_reg <= radius_sq && (!found_reg || acc_reg < best_reg))
        begin
            found_reg <= 1'b1;
            best_reg  <= acc_reg;
        end
    end

    // ---------------- root and result ----------------
    newr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (best_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found            <= found_reg;
            min_dist_squared <= best_reg;
            min_distance_fx  <= root;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/nearest_euclidean_within_radius.sv
// Flow: a load, clear or non-final query beat is absorbed without a result; the final query beat
//   yields its result after the scan, the 4-stage pipe and the 28-step root.
// Throughput: input takes one beat a cycle while the 4-entry queue has room; the back end
//   handles one coordinate per cycle while it scans, so a query scans points*dimension coordinates.
// Reset: rst_n is asynchronous, active low; clears counts, indexes, queue and result valid.
//   Point store and query buffer are not cleared; dimension=128, radius_squared=90000.

module nearest_euclidean_within_radius #(
    parameter int MAX_POINTS = newr_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIM    = newr_pkg::MAX_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [newr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [newr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [newr_pkg::OP_W-1:0]           op,
    input  logic signed [newr_pkg::COORD_W-1:0] coord_value,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [newr_pkg::DIST_W-1:0]         min_dist_squared,
    output logic [newr_pkg::ROOT_W-1:0]         min_distance_fx
);

    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int SAW = (MAX_POINTS * MAX_DIM > 1) ? $clog2(MAX_POINTS * MAX_DIM) : 1;
    localparam int CRD = newr_pkg::COORD_W;
    // queue beat: kind, last, coordinate, address, point count
    localparam int QW  = 2 + CRD + SAW + CW;

    // configuration registers
    logic [newr_pkg::DIM_CFG_W-1:0] dimension_reg;
    logic [newr_pkg::DIST_W-1:0]    radius_sq_reg;
    logic [DW-1:0]                  eff_dim;

    // front to queue
    logic                  push;
    newr_pkg::cmd_kind_t   cmd_kind;
    logic                  cmd_last;
    logic [CRD-1:0]        cmd_coord;
    logic [SAW-1:0]        cmd_addr;
    logic [CW-1:0]         cmd_count;
    logic                  q_full, q_empty, q_pop;
    logic [QW-1:0]         q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= newr_pkg::DIM_RESET;
            radius_sq_reg <= newr_pkg::RADIUS_SQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                newr_pkg::REG_DIMENSION: dimension_reg <= cfg_data[newr_pkg::DIM_CFG_W-1:0];
                newr_pkg::REG_RADIUS:    radius_sq_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // zero behaves as one, anything above MAX_DIM as MAX_DIM
    always_comb
    begin
        if (dimension_reg == '0)
        begin
            eff_dim = DW'(1);
        end
        else if (32'(dimension_reg) > 32'(MAX_DIM))
        begin
            eff_dim = DW'(MAX_DIM);
        end
        else
        begin
            eff_dim = DW'(dimension_reg);
        end
    end

    // front end: classify beats, keep load/query indexes and the point count
    newr_front #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIM    (MAX_DIM)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .coord_value (coord_value),
        .dim         (eff_dim),
        .q_full      (q_full),
        .push        (push),
        .cmd_kind    (cmd_kind),
        .cmd_last    (cmd_last),
        .cmd_coord   (cmd_coord),
        .cmd_addr    (cmd_addr),
        .cmd_count   (cmd_count)
    );

    // command queue; lets loads keep flowing while a scan runs, until the queue is full
    newr_queue #(
        .WIDTH (QW),
        .DEPTH (newr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({cmd_kind, cmd_last, cmd_coord, cmd_addr, cmd_count}),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back end: store writes, scan, root, result register
    newr_back #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIM    (MAX_DIM)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .dim              (eff_dim),
        .radius_sq        (radius_sq_reg),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .h_kind           (newr_pkg::cmd_kind_t'(q_head[QW-1])),
        .h_last           (q_head[QW-2]),
        .h_coord          (q_head[QW-3 -: CRD]),
        .h_addr           (q_head[CW +: SAW]),
        .h_count          (q_head[CW-1:0]),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .found            (found),
        .min_dist_squared (min_dist_squared),
        .min_distance_fx  (min_distance_fx)
    );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for nearest_euclidean_within_radius: loads points, runs queries, and
// checks every search result against an in-bench predictor. Depends on rtl/newr_pkg.sv and the RTL.
`timescale 1ns / 100ps

module tb;

    typedef logic signed [newr_pkg::COORD_W-1:0] coord_t;
    typedef logic [newr_pkg::CFG_DATA_W-1:0]     cfg_word_t;
    typedef logic [newr_pkg::DIM_CFG_W-1:0]      dim_word_t;

    localparam int N_POINTS = newr_pkg::MAX_POINTS_DEF;
    localparam int N_DIM    = newr_pkg::MAX_DIM_DEF;

    // op 3 has no meaning in the block; it must be swallowed without a result
    localparam logic [newr_pkg::OP_W-1:0] OP_NOP = 2'd3;

    localparam coord_t COORD_MIN = 16'h8000;
    localparam coord_t COORD_MAX = 16'h7fff;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_BEATS = 150;
    // Quiet time after the last result: lets queued loads retire before a
    // register write, and catches stray results at the end.
    localparam int          DRAIN_CYCLES = 300;

    typedef struct packed {
        logic                        found;
        logic [newr_pkg::DIST_W-1:0] dist_sq;
        logic [newr_pkg::ROOT_W-1:0] root;
    } search_result_t;

    // Scoreboard: mirrors the point store, the query buffer and both registers,
    // and keeps the search results still owed by the block.
    class nearest_match_tracker;
        bit signed [newr_pkg::COORD_W-1:0] stored_coords [N_POINTS*N_DIM];
        bit signed [newr_pkg::COORD_W-1:0] query_coords [N_DIM];
        int unsigned                       point_total;
        int unsigned                       load_pos;
        int unsigned                       query_pos;
        bit [newr_pkg::DIM_CFG_W-1:0]      dim_setting;
        bit [newr_pkg::DIST_W-1:0]         radius_limit;
        search_result_t                    pending_answers [$];
        int unsigned                       mismatches;

        function new();
            dim_setting  = newr_pkg::DIM_RESET;
            radius_limit = newr_pkg::RADIUS_SQ_RESET;
        endfunction

        function int unsigned active_dim();
            if (dim_setting == 0)
                return 1;
            if (dim_setting > N_DIM)
                return N_DIM;
            return dim_setting;
        endfunction

        function void set_reg(logic [newr_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
            if (idx == newr_pkg::REG_DIMENSION)
                dim_setting = data[newr_pkg::DIM_CFG_W-1:0];
            else
                radius_limit = data;
        endfunction

        function bit [newr_pkg::ROOT_W-1:0] root_fx(bit [newr_pkg::DIST_W-1:0] dist_sq);
            longint unsigned             scaled;
            longint unsigned             trial;
            bit [newr_pkg::ROOT_W-1:0]   root;
            scaled = {8'b0, dist_sq, 16'b0};
            root   = '0;
            for (int b = newr_pkg::ROOT_W - 1; b >= 0; b--)
            begin
                root[b] = 1'b1;
                trial   = root;
                if (trial * trial > scaled)
                    root[b] = 1'b0;
            end
            return root;
        endfunction

        function search_result_t nearest_within_radius(int unsigned d);
            search_result_t  r;
            longint unsigned sum;
            longint          diff;
            r = '0;
            for (int unsigned p = 0; p < point_total; p++)
            begin
                sum = 0;
                for (int unsigned q = 0; q < d; q++)
                begin
                    diff = longint'(stored_coords[p * N_DIM + q]) - longint'(query_coords[q]);
                    sum += diff * diff;
                    if (sum > newr_pkg::DIST_MAX)
                        sum = newr_pkg::DIST_MAX;
                end
                if (sum <= radius_limit && (!r.found || sum < r.dist_sq))
                begin
                    r.found   = 1'b1;
                    r.dist_sq = sum[newr_pkg::DIST_W-1:0];
                end
            end
            r.root = root_fx(r.dist_sq);
            return r;
        endfunction

        function void note_beat(logic [newr_pkg::OP_W-1:0] kind, coord_t value);
            int unsigned d;
            d = active_dim();
            case (kind)
                newr_pkg::OP_LOAD:
                    if (point_total < N_POINTS)
                    begin
                        stored_coords[point_total * N_DIM + load_pos] = value;
                        load_pos++;
                        if (load_pos >= d)
                        begin
                            load_pos = 0;
                            point_total++;
                        end
                    end
                newr_pkg::OP_QUERY:
                begin
                    query_coords[query_pos] = value;
                    query_pos++;
                    if (query_pos >= d)
                    begin
                        query_pos = 0;
                        pending_answers = {pending_answers, nearest_within_radius(d)};
                    end
                end
                newr_pkg::OP_CLEAR:
                begin
                    point_total = 0;
                    load_pos    = 0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic f, logic [newr_pkg::DIST_W-1:0] got_dist,
                                   logic [newr_pkg::ROOT_W-1:0] rt);
            search_result_t want;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result: found=%0d dist=%0d root=%0d",
                             $time, f, got_dist, rt);
                return;
            end
            want = pending_answers.pop_front();
            if (f !== want.found || got_dist !== want.dist_sq || rt !== want.root)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result mismatch: expected found=%0d dist=%0d root=%0d,",
                              " got found=%0d dist=%0d root=%0d"},
                             $time, want.found, want.dist_sq, want.root, f, got_dist, rt);
            end
        endfunction
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [newr_pkg::CFG_IDX_W-1:0]      cfg_index;
    cfg_word_t                           cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic [newr_pkg::OP_W-1:0]           op;
    coord_t                              coord_value;
    logic                                out_valid;
    logic                                out_ready;
    logic                                found;
    logic [newr_pkg::DIST_W-1:0]         min_dist_squared;
    logic [newr_pkg::ROOT_W-1:0]         min_distance_fx;

    nearest_match_tracker tracker;
    bit                   steady;       // when set, neither side inserts idle cycles
    int unsigned          beats_sent;
    int unsigned          cycles;

    nearest_euclidean_within_radius i_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: values read right after the edge are the ones the block presented,
    // so a beat is taken exactly when out_valid and out_ready were both high.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            tracker.check_result(found, min_dist_squared, min_distance_fx);
        out_ready <= steady || ($urandom_range(99) >= 20);
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2, 3:    return coord_t'($urandom());
            default: return coord_t'(int'($urandom_range(400)) - 200);
        endcase
    endfunction

    // A coordinate close to a given one, clamped to the 16-bit range
    function automatic coord_t nudge(coord_t base);
        int v;
        v = int'(base) + int'($urandom_range(24)) - 12;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    // One input beat. valid is only dropped when a gap is taken, so back-to-back beats
    // never see a low and a high scheduled in the same step.
    task automatic send_beat(input logic [newr_pkg::OP_W-1:0] kind, input coord_t value);
        if (!steady && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        coord_value <= value;
        do @(posedge clk); while (!in_ready);
        tracker.note_beat(kind, value);
        beats_sent++;
    endtask

    // Finishes the point or query vector in progress. With near set, the coordinates
    // track a stored point so that radius hits are common.
    task automatic send_vector(input logic [newr_pkg::OP_W-1:0] kind, input bit near);
        int unsigned d;
        int unsigned pos;
        int unsigned anchor;
        bit          use_anchor;
        d          = tracker.active_dim();
        pos        = (kind == newr_pkg::OP_LOAD) ? tracker.load_pos : tracker.query_pos;
        use_anchor = near && tracker.point_total > 0;
        anchor     = use_anchor ? $urandom_range(tracker.point_total - 1) : 0;
        do
        begin
            if (use_anchor)
                send_beat(kind, nudge(tracker.stored_coords[anchor * N_DIM + pos]));
            else
                send_beat(kind, pick_coord());
            pos++;
        end
        while (pos < d);
    endtask

    // Hold the sender until every owed result is in, then let queued beats retire
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [newr_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // One random episode: new settings, optional clear, a few points, a few queries.
    // A dimension increase is always preceded by a clear so that the scan never
    // touches store entries that were never written.
    task automatic random_phase();
        int unsigned old_dim;
        int unsigned r;
        dim_word_t   dsel;
        cfg_word_t   rad;
        old_dim = tracker.active_dim();
        case ($urandom_range(9))
            0:       dsel = '0;
            1:       dsel = dim_word_t'($urandom_range(12, 7));
            default: dsel = dim_word_t'($urandom_range(5, 1));
        endcase
        case ($urandom_range(5))
            0:       rad = '0;
            1:       rad = newr_pkg::DIST_MAX;
            2:       rad = cfg_word_t'({$urandom(), $urandom()});
            3:
            begin
                r   = $urandom_range(300);
                rad = cfg_word_t'(r * r);
            end
            default: rad = cfg_word_t'($urandom_range(3000));
        endcase
        settle();
        write_reg(newr_pkg::REG_DIMENSION, cfg_word_t'(dsel));
        write_reg(newr_pkg::REG_RADIUS, rad);
        if (tracker.active_dim() > old_dim || $urandom_range(1))
            send_beat(newr_pkg::OP_CLEAR, pick_coord());
        repeat ($urandom_range(8))
            send_vector(newr_pkg::OP_LOAD, $urandom_range(3) == 0);
        repeat ($urandom_range(6, 1))
        begin
            // some noise between queries: unused op, clear, or a stray coordinate
            // that leaves a point half loaded
            case ($urandom_range(19))
                0:       send_beat(OP_NOP, pick_coord());
                1:       send_beat(newr_pkg::OP_CLEAR, pick_coord());
                2:       send_beat(newr_pkg::OP_LOAD, pick_coord());
                default: ;
            endcase
            send_vector(newr_pkg::OP_QUERY, $urandom_range(3) != 0);
        end
    endtask

    initial
    begin
        int unsigned random_start;
        tracker     = new();
        steady      = 1'b0;
        beats_sent  = 0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        op          <= '0;
        coord_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (dimension 128, radius 300 squared): one full-size point and a
        // query close to it, so the hit relies on both reset values. Long stretch with
        // no idling on either side.
        steady = 1'b1;
        send_vector(newr_pkg::OP_LOAD, 1'b0);
        send_vector(newr_pkg::OP_QUERY, 1'b1);
        settle();
        steady = 1'b0;
        // dimension above the maximum behaves as the maximum
        write_reg(newr_pkg::REG_DIMENSION, cfg_word_t'(255));
        send_vector(newr_pkg::OP_QUERY, 1'b0);

        // Directed, dimension 2
        settle();
        write_reg(newr_pkg::REG_DIMENSION, cfg_word_t'(2));
        send_beat(newr_pkg::OP_CLEAR, '0);
        send_beat(newr_pkg::OP_QUERY, coord_t'(5));      // empty store: nothing found
        send_beat(newr_pkg::OP_QUERY, coord_t'(-5));
        send_beat(newr_pkg::OP_LOAD, COORD_MAX);
        send_beat(newr_pkg::OP_LOAD, COORD_MIN);
        send_beat(newr_pkg::OP_LOAD, '0);
        send_beat(newr_pkg::OP_LOAD, '0);
        send_beat(OP_NOP, COORD_MAX);                    // ignored, no result
        send_beat(newr_pkg::OP_QUERY, COORD_MAX);        // exact hit on the corner point
        send_beat(newr_pkg::OP_QUERY, COORD_MIN);
        send_beat(newr_pkg::OP_QUERY, coord_t'(100));    // inside the reset radius of the origin
        send_beat(newr_pkg::OP_QUERY, coord_t'(200));
        send_beat(newr_pkg::OP_QUERY, coord_t'(3));      // clear lands mid-query
        send_beat(newr_pkg::OP_CLEAR, '0);
        send_beat(newr_pkg::OP_QUERY, coord_t'(4));
        settle();
        write_reg(newr_pkg::REG_RADIUS, newr_pkg::DIST_MAX);
        send_beat(newr_pkg::OP_LOAD, COORD_MIN);
        send_beat(newr_pkg::OP_LOAD, COORD_MAX);
        send_beat(newr_pkg::OP_QUERY, COORD_MAX);        // largest distance the fields allow
        send_beat(newr_pkg::OP_QUERY, COORD_MIN);
        settle();
        write_reg(newr_pkg::REG_RADIUS, '0);
        send_beat(newr_pkg::OP_QUERY, COORD_MIN);        // radius zero: exact match only
        send_beat(newr_pkg::OP_QUERY, COORD_MAX);
        send_beat(newr_pkg::OP_QUERY, coord_t'(COORD_MIN + 1)); // distance one: rejected
        send_beat(newr_pkg::OP_QUERY, COORD_MAX);

        // Dimension shrinks while a point and a query are both part-way through:
        // the next coordinate completes each of them.
        settle();
        write_reg(newr_pkg::REG_DIMENSION, cfg_word_t'(4));
        write_reg(newr_pkg::REG_RADIUS, newr_pkg::DIST_MAX);
        send_beat(newr_pkg::OP_CLEAR, '0);
        repeat (3) send_beat(newr_pkg::OP_LOAD, pick_coord());
        repeat (3) send_beat(newr_pkg::OP_QUERY, pick_coord());
        settle();
        write_reg(newr_pkg::REG_DIMENSION, cfg_word_t'(2));
        send_beat(newr_pkg::OP_LOAD, pick_coord());
        send_beat(newr_pkg::OP_QUERY, pick_coord());

        // Random episodes
        random_start = beats_sent;
        while (beats_sent < random_start + RANDOM_BEATS)
            random_phase();

        in_valid <= 1'b0;
        while (tracker.pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
